@@ rtl/core/pcls_pkg.sv @@
// ----------------------------------------------------------------------------
// pcls_pkg: shared types and constants of the patterned clipped line stepper
// Holds widths, command and outcode names, and the request and response
// bundles between the sequencer and the shared multiply-divide unit.
// ----------------------------------------------------------------------------
package pcls_pkg;

    // Widths of the beat fields
    localparam int IN_W   = 16;
    localparam int PIXW   = 12;
    localparam int PATW   = 16;
    localparam int PIDXW  = 4;

    // Bresenham state widths
    localparam int DELW   = PIXW + 1;
    localparam int ERRW   = PIXW + 2;

    // Clip arithmetic: coordinates, operands, product
    localparam int CW     = 20;
    localparam int OPW    = CW + 1;
    localparam int PRW    = 2 * OPW;
    localparam int CNTW   = 6;

    // Commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Outcode bits
    localparam logic [3:0] OC_LEFT   = 4'b0001;
    localparam logic [3:0] OC_RIGHT  = 4'b0010;
    localparam logic [3:0] OC_BELOW  = 4'b0100;
    localparam logic [3:0] OC_ABOVE  = 4'b1000;
    localparam logic [3:0] OC_NONE   = 4'b0000;
    localparam logic [3:0] OC_Y_MASK = OC_BELOW | OC_ABOVE;

    typedef struct packed {
        logic                  start;
        logic signed [OPW-1:0] fa;
        logic signed [OPW-1:0] fb;
        logic signed [OPW-1:0] den;
    } t_md_req;

    typedef struct packed {
        logic                  done;
        logic signed [OPW-1:0] quot;
    } t_md_rsp;

endpackage

@@ rtl/core/pcls_muldiv.sv @@
// ----------------------------------------------------------------------------
// pcls_muldiv: shared multiply then divide unit
// Computes (fa * fb) / den truncated toward zero, one quotient bit a cycle
// by restoring division; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module pcls_muldiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcls_pkg::t_md_req  i_req,
    output pcls_pkg::t_md_rsp  o_rsp
);

    typedef enum logic [4:0] {
        MD_IDLE = 5'b00001,
        MD_MUL  = 5'b00010,
        MD_ABS  = 5'b00100,
        MD_DIV  = 5'b01000,
        MD_FIX  = 5'b10000
    } t_md_state;

    t_md_state                            r_state, n_state;
    logic signed [pcls_pkg::OPW-1:0]      r_fa, r_fb;
    logic        [pcls_pkg::OPW-1:0]      r_dmag;
    logic                                 r_dneg;
    logic signed [pcls_pkg::PRW-1:0]      r_prod;
    logic        [pcls_pkg::PRW-1:0]      r_quo;
    logic        [pcls_pkg::OPW:0]        r_rem;
    logic                                 r_neg;
    logic        [pcls_pkg::CNTW-1:0]     r_cnt;

    logic signed [pcls_pkg::PRW-1:0]      w_prod;
    logic        [pcls_pkg::OPW:0]        w_rem_sh;
    logic        [pcls_pkg::OPW+1:0]      w_diff;
    logic signed [pcls_pkg::OPW-1:0]      w_qmag;

    assign w_prod   = r_fa * r_fb;
    assign w_rem_sh = {r_rem[pcls_pkg::OPW-1:0], r_quo[pcls_pkg::PRW-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_dmag};
    assign w_qmag   = r_quo[pcls_pkg::OPW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            MD_IDLE: if (i_req.start) n_state = MD_MUL;
            MD_MUL:  n_state = MD_ABS;
            MD_ABS:  n_state = MD_DIV;
            MD_DIV:  if (r_cnt == pcls_pkg::CNTW'(pcls_pkg::PRW - 1)) n_state = MD_FIX;
            MD_FIX:  n_state = MD_IDLE;
            default: n_state = MD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: latch operands, multiply, take magnitudes, shift-subtract
    always_ff @(posedge i_clk) begin
        case (r_state)
            MD_IDLE: begin
                r_fa   <= i_req.fa;
                r_fb   <= i_req.fb;
                r_dneg <= i_req.den[pcls_pkg::OPW-1];
                r_dmag <= i_req.den[pcls_pkg::OPW-1] ? -i_req.den : i_req.den;
            end
            MD_MUL: begin
                r_prod <= w_prod;
            end
            MD_ABS: begin
                r_quo <= r_prod[pcls_pkg::PRW-1] ? -r_prod : r_prod;
                r_neg <= r_prod[pcls_pkg::PRW-1] ^ r_dneg;
                r_rem <= '0;
                r_cnt <= '0;
            end
            MD_DIV: begin
                r_cnt <= r_cnt + pcls_pkg::CNTW'(1);
                if (!w_diff[pcls_pkg::OPW+1]) begin
                    r_rem <= w_diff[pcls_pkg::OPW:0];
                    r_quo <= {r_quo[pcls_pkg::PRW-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_quo <= {r_quo[pcls_pkg::PRW-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done = (r_state == MD_FIX);
    assign o_rsp.quot = (r_dmag == '0) ? '0 : (r_neg ? -w_qmag : w_qmag);

endmodule

@@ rtl/core/patterned_clipped_line_stepper.sv @@
// A tick beat shows at the output the cycle after the edge that takes it.
// Ticks stream one per cycle while the output side keeps taking beats.
// A start beat passes the y check, then, if it needs clipping, the y clip divisions,
// the x check and the x clip divisions (at most four, on the shared multiply-divide
// unit), then the setup state. No beat is taken while a start is being clipped.
// Reset (synchronous, active low) leaves the block idle with no line active.
// ----------------------------------------------------------------------------
// patterned_clipped_line_stepper: clipped Bresenham line with a dash pattern
// A start beat clips two signed endpoints to the screen by outcodes and answers with
// the first pixel or a rejected beat; each tick beat on an active line advances one
// step along the major axis and answers with the next pixel and its pattern bit.
// ----------------------------------------------------------------------------
module patterned_clipped_line_stepper #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic signed [pcls_pkg::IN_W-1:0]  i_start_x,
    input  logic signed [pcls_pkg::IN_W-1:0]  i_start_y,
    input  logic signed [pcls_pkg::IN_W-1:0]  i_end_x,
    input  logic signed [pcls_pkg::IN_W-1:0]  i_end_y,
    input  logic        [pcls_pkg::PATW-1:0]  i_dash_pattern,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic        [pcls_pkg::PIXW-1:0]  o_pixel_x,
    output logic        [pcls_pkg::PIXW-1:0]  o_pixel_y,
    output logic                              o_plot,
    output logic                              o_last,
    output logic                              o_rejected
);

    localparam int CW    = pcls_pkg::CW;
    localparam int OPW   = pcls_pkg::OPW;
    localparam int PIXW  = pcls_pkg::PIXW;
    localparam int DELW  = pcls_pkg::DELW;
    localparam int ERRW  = pcls_pkg::ERRW;
    localparam int IN_W  = pcls_pkg::IN_W;

    // Clip limits: columns 0..W-1 are inside, rows 0..H-2 are inside
    localparam logic signed [CW-1:0] X_LIM  = CW'(SCREEN_WIDTH);
    localparam logic signed [CW-1:0] X_MAX  = CW'(SCREEN_WIDTH - 1);
    localparam logic signed [CW-1:0] Y_LIM  = CW'(SCREEN_HEIGHT - 1);
    localparam logic signed [CW-1:0] Y_MAX  = CW'(SCREEN_HEIGHT - 2);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_YCHK   = 9'b000000010,
        ST_YA     = 9'b000000100,
        ST_YB     = 9'b000001000,
        ST_XCHK   = 9'b000010000,
        ST_XA     = 9'b000100000,
        ST_XB     = 9'b001000000,
        ST_SETUP  = 9'b010000000,
        ST_REJECT = 9'b100000000
    } t_state;

    function automatic logic [3:0] f_ocode(input logic signed [CW-1:0] x,
                                           input logic signed [CW-1:0] y);
        logic [3:0] c;
        c = pcls_pkg::OC_NONE;
        if (x < 0)      c = c | pcls_pkg::OC_LEFT;
        if (x >= X_LIM) c = c | pcls_pkg::OC_RIGHT;
        if (y < 0)      c = c | pcls_pkg::OC_BELOW;
        if (y >= Y_LIM) c = c | pcls_pkg::OC_ABOVE;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                         r_state, n_state;
    logic                           r_issued, n_issued;

    // clip endpoints, widened so intermediate clip points never wrap
    logic signed [CW-1:0]           r_ax, n_ax, r_ay, n_ay;
    logic signed [CW-1:0]           r_bx, n_bx, r_by, n_by;

    // line stepping state
    logic [PIXW-1:0]                r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic signed [ERRW-1:0]         r_err, n_err;
    logic [PIXW-1:0]                r_steps, n_steps;
    logic                           r_xneg, n_xneg, r_yneg, n_yneg;
    logic                           r_xmaj, n_xmaj;
    logic [DELW-1:0]                r_mnr2, n_mnr2, r_maj2, n_maj2;
    logic [pcls_pkg::PATW-1:0]      r_pat, n_pat;
    logic [pcls_pkg::PIDXW-1:0]     r_pidx, n_pidx;
    logic                           r_active, n_active;

    // output register
    logic                           r_ov, n_ov;
    logic [PIXW-1:0]                r_px, n_px, r_py, n_py;
    logic                           r_plot, n_plot, r_last, n_last, r_rej, n_rej;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic w_slot, w_in_acc;

    // the output register may be reloaded when empty or being drained
    assign w_slot     = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_slot;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Outcodes and clip targets, taken from the endpoint registers
    // ------------------------------------------------------------------
    logic [3:0]            w_ca, w_cb;
    logic                  w_clip_cond;
    logic signed [CW-1:0]  w_tgt_ya, w_tgt_yb, w_tgt_xa, w_tgt_xb;

    assign w_ca        = f_ocode(r_ax, r_ay);
    assign w_cb        = f_ocode(r_bx, r_by);
    // trivially outside when both share a side; trivially inside when both are zero
    assign w_clip_cond = ((w_ca & w_cb) == pcls_pkg::OC_NONE) &&
                         ((w_ca | w_cb) != pcls_pkg::OC_NONE);

    assign w_tgt_ya = ((w_ca & pcls_pkg::OC_ABOVE) != pcls_pkg::OC_NONE) ? Y_MAX : '0;
    assign w_tgt_yb = ((w_cb & pcls_pkg::OC_ABOVE) != pcls_pkg::OC_NONE) ? Y_MAX : '0;
    assign w_tgt_xa = (w_ca == pcls_pkg::OC_LEFT) ? '0 : X_MAX;
    assign w_tgt_xb = (w_cb == pcls_pkg::OC_LEFT) ? '0 : X_MAX;

    // sign-extended copies for operand arithmetic
    logic signed [OPW-1:0] w_ax_e, w_ay_e, w_bx_e, w_by_e;
    logic signed [OPW-1:0] w_dx_e, w_dy_e;

    assign w_ax_e = {r_ax[CW-1], r_ax};
    assign w_ay_e = {r_ay[CW-1], r_ay};
    assign w_bx_e = {r_bx[CW-1], r_bx};
    assign w_by_e = {r_by[CW-1], r_by};
    assign w_dx_e = w_bx_e - w_ax_e;
    assign w_dy_e = w_by_e - w_ay_e;

    // ------------------------------------------------------------------
    // Shared multiply-divide unit: one clip division at a time
    // ------------------------------------------------------------------
    pcls_pkg::t_md_req  w_md_req;
    pcls_pkg::t_md_rsp  w_md_rsp;
    logic signed [CW-1:0] w_quot;

    assign w_quot = w_md_rsp.quot[CW-1:0];

    always_comb begin
        w_md_req.start = 1'b0;
        w_md_req.fa    = '0;
        w_md_req.fb    = '0;
        w_md_req.den   = '0;
        case (r_state)
            ST_YA: begin
                // x shift of a while moving it onto the clip row
                w_md_req.start = !r_issued;
                w_md_req.fa    = {w_tgt_ya[CW-1], w_tgt_ya} - w_ay_e;
                w_md_req.fb    = w_dx_e;
                w_md_req.den   = w_dy_e;
            end
            ST_YB: begin
                w_md_req.start = !r_issued;
                w_md_req.fa    = {w_tgt_yb[CW-1], w_tgt_yb} - w_by_e;
                w_md_req.fb    = w_dx_e;
                w_md_req.den   = w_dy_e;
            end
            ST_XA: begin
                // y shift of a while moving it onto the clip column
                w_md_req.start = !r_issued;
                w_md_req.fa    = {w_tgt_xa[CW-1], w_tgt_xa} - w_ax_e;
                w_md_req.fb    = w_dy_e;
                w_md_req.den   = w_dx_e;
            end
            ST_XB: begin
                w_md_req.start = !r_issued;
                w_md_req.fa    = {w_tgt_xb[CW-1], w_tgt_xb} - w_bx_e;
                w_md_req.fb    = w_dy_e;
                w_md_req.den   = w_dx_e;
            end
            default: begin
            end
        endcase
    end

    pcls_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .o_rsp   (w_md_rsp)
    );

    // ------------------------------------------------------------------
    // Line setup from the clipped endpoints (all inside the screen now)
    // ------------------------------------------------------------------
    logic [PIXW-1:0]        w_sx, w_sy, w_ex, w_ey;
    logic signed [DELW-1:0] w_ddx, w_ddy;
    logic [PIXW-1:0]        w_adx, w_ady, w_maj, w_mnr;
    logic                   w_xmaj;
    logic signed [ERRW-1:0] w_err0;

    assign w_sx   = r_ax[PIXW-1:0];
    assign w_sy   = r_ay[PIXW-1:0];
    assign w_ex   = r_bx[PIXW-1:0];
    assign w_ey   = r_by[PIXW-1:0];
    assign w_ddx  = {1'b0, w_sx} - {1'b0, w_ex};
    assign w_ddy  = {1'b0, w_sy} - {1'b0, w_ey};
    assign w_adx  = w_ddx[DELW-1] ? PIXW'(-w_ddx) : w_ddx[PIXW-1:0];
    assign w_ady  = w_ddy[DELW-1] ? PIXW'(-w_ddy) : w_ddy[PIXW-1:0];
    assign w_xmaj = w_adx > w_ady;
    assign w_maj  = w_xmaj ? w_adx : w_ady;
    assign w_mnr  = w_xmaj ? w_ady : w_adx;
    assign w_err0 = {1'b0, w_mnr, 1'b0} - {2'b00, w_maj};

    // ------------------------------------------------------------------
    // One Bresenham step
    // ------------------------------------------------------------------
    logic                        w_minor;
    logic signed [ERRW:0]        w_err_sum;
    logic [PIXW-1:0]             w_x_step, w_y_step, w_nx, w_ny, w_steps_n;
    logic [pcls_pkg::PIDXW-1:0]  w_pidx_n;
    logic                        w_act_n;

    assign w_minor   = !r_err[ERRW-1];
    assign w_err_sum = {r_err[ERRW-1], r_err} + {2'b00, r_mnr2}
                     - (w_minor ? {2'b00, r_maj2} : '0);
    assign w_x_step  = r_xneg ? r_cur_x - PIXW'(1) : r_cur_x + PIXW'(1);
    assign w_y_step  = r_yneg ? r_cur_y - PIXW'(1) : r_cur_y + PIXW'(1);
    assign w_nx      = (r_xmaj || w_minor) ? w_x_step : r_cur_x;
    assign w_ny      = (!r_xmaj || w_minor) ? w_y_step : r_cur_y;
    assign w_pidx_n  = r_pidx + pcls_pkg::PIDXW'(1);
    assign w_steps_n = r_steps - PIXW'(1);
    assign w_act_n   = (w_steps_n != '0);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_issued = r_issued;
        n_ax     = r_ax;
        n_ay     = r_ay;
        n_bx     = r_bx;
        n_by     = r_by;
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_err    = r_err;
        n_steps  = r_steps;
        n_xneg   = r_xneg;
        n_yneg   = r_yneg;
        n_xmaj   = r_xmaj;
        n_mnr2   = r_mnr2;
        n_maj2   = r_maj2;
        n_pat    = r_pat;
        n_pidx   = r_pidx;
        n_active = r_active;
        n_ov     = r_ov && !i_out_ready;
        n_px     = r_px;
        n_py     = r_py;
        n_plot   = r_plot;
        n_last   = r_last;
        n_rej    = r_rej;

        // hold off a second issue until the unit answers
        if (w_md_req.start) n_issued = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_command == pcls_pkg::CMD_START) begin
                        // capture endpoints and pattern, then clip
                        n_ax    = {{(CW-IN_W){i_start_x[IN_W-1]}}, i_start_x};
                        n_ay    = {{(CW-IN_W){i_start_y[IN_W-1]}}, i_start_y};
                        n_bx    = {{(CW-IN_W){i_end_x[IN_W-1]}}, i_end_x};
                        n_by    = {{(CW-IN_W){i_end_y[IN_W-1]}}, i_end_y};
                        n_pat   = i_dash_pattern;
                        n_pidx  = '0;
                        n_state = ST_YCHK;
                    end else if (!r_active) begin
                        // idle tick: answer with an empty last beat
                        n_ov   = 1'b1;
                        n_px   = '0;
                        n_py   = '0;
                        n_plot = 1'b0;
                        n_last = 1'b1;
                        n_rej  = 1'b0;
                    end else begin
                        // advance one step along the major axis
                        n_err    = w_err_sum[ERRW-1:0];
                        n_cur_x  = w_nx;
                        n_cur_y  = w_ny;
                        n_pidx   = w_pidx_n;
                        n_steps  = w_steps_n;
                        n_active = w_act_n;
                        n_ov     = 1'b1;
                        n_px     = w_nx;
                        n_py     = w_ny;
                        n_plot   = r_pat[w_pidx_n];
                        n_last   = !w_act_n;
                        n_rej    = 1'b0;
                    end
                end
            end
            ST_YCHK: begin
                if (w_clip_cond) begin
                    if ((w_ca & pcls_pkg::OC_Y_MASK) != pcls_pkg::OC_NONE) begin
                        n_state = ST_YA;
                    end else if ((w_cb & pcls_pkg::OC_Y_MASK) != pcls_pkg::OC_NONE) begin
                        n_state = ST_YB;
                    end else begin
                        n_state = ST_XCHK;
                    end
                end else if ((w_ca | w_cb) == pcls_pkg::OC_NONE) begin
                    n_state = ST_SETUP;
                end else begin
                    n_state = ST_REJECT;
                end
            end
            ST_YA: begin
                if (w_md_rsp.done) begin
                    n_ax     = r_ax + w_quot;
                    n_ay     = w_tgt_ya;
                    n_issued = 1'b0;
                    n_state  = ((w_cb & pcls_pkg::OC_Y_MASK) != pcls_pkg::OC_NONE) ?
                               ST_YB : ST_XCHK;
                end
            end
            ST_YB: begin
                if (w_md_rsp.done) begin
                    n_bx     = r_bx + w_quot;
                    n_by     = w_tgt_yb;
                    n_issued = 1'b0;
                    n_state  = ST_XCHK;
                end
            end
            ST_XCHK: begin
                // both rows are inside now; only column codes remain
                if (w_clip_cond) begin
                    if (w_ca != pcls_pkg::OC_NONE) begin
                        n_state = ST_XA;
                    end else begin
                        n_state = ST_XB;
                    end
                end else if ((w_ca | w_cb) == pcls_pkg::OC_NONE) begin
                    n_state = ST_SETUP;
                end else begin
                    n_state = ST_REJECT;
                end
            end
            ST_XA: begin
                if (w_md_rsp.done) begin
                    n_ay     = r_ay + w_quot;
                    n_ax     = w_tgt_xa;
                    n_issued = 1'b0;
                    n_state  = (w_cb != pcls_pkg::OC_NONE) ? ST_XB : ST_SETUP;
                end
            end
            ST_XB: begin
                if (w_md_rsp.done) begin
                    n_by     = r_by + w_quot;
                    n_bx     = w_tgt_xb;
                    n_issued = 1'b0;
                    n_state  = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (w_slot) begin
                    n_xneg   = !w_ddx[DELW-1];
                    n_yneg   = !w_ddy[DELW-1];
                    n_xmaj   = w_xmaj;
                    n_maj2   = {w_maj, 1'b0};
                    n_mnr2   = {w_mnr, 1'b0};
                    n_err    = w_err0;
                    n_steps  = w_maj;
                    n_cur_x  = w_sx;
                    n_cur_y  = w_sy;
                    n_active = (w_maj != '0);
                    n_ov     = 1'b1;
                    n_px     = w_sx;
                    n_py     = w_sy;
                    n_plot   = r_pat[0];
                    n_last   = (w_maj == '0);
                    n_rej    = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            ST_REJECT: begin
                if (w_slot) begin
                    n_active = 1'b0;
                    n_steps  = '0;
                    n_ov     = 1'b1;
                    n_px     = '0;
                    n_py     = '0;
                    n_plot   = 1'b0;
                    n_last   = 1'b1;
                    n_rej    = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
            r_active <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_active <= n_active;
            r_ov     <= n_ov;
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        r_ax    <= n_ax;
        r_ay    <= n_ay;
        r_bx    <= n_bx;
        r_by    <= n_by;
        r_cur_x <= n_cur_x;
        r_cur_y <= n_cur_y;
        r_err   <= n_err;
        r_steps <= n_steps;
        r_xneg  <= n_xneg;
        r_yneg  <= n_yneg;
        r_xmaj  <= n_xmaj;
        r_mnr2  <= n_mnr2;
        r_maj2  <= n_maj2;
        r_pat   <= n_pat;
        r_pidx  <= n_pidx;
        r_px    <= n_px;
        r_py    <= n_py;
        r_plot  <= n_plot;
        r_last  <= n_last;
        r_rej   <= n_rej;
    end

    assign o_out_valid = r_ov;
    assign o_pixel_x   = r_px;
    assign o_pixel_y   = r_py;
    assign o_plot      = r_plot;
    assign o_last      = r_last;
    assign o_rejected  = r_rej;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_start_clips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_command == pcls_pkg::CMD_START)) |=> (r_state == ST_YCHK))
        else $error("start beat did not enter the clip check");

    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_rsp.done |-> r_issued)
        else $error("divide unit answered without a pending request");

    a_active_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_steps != '0))
        else $error("line active with no steps left");

    a_reject_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_rej) |-> (r_last && !r_plot && (r_px == '0) && (r_py == '0)))
        else $error("rejected beat carries a pixel");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the patterned clipped line stepper
// Streams start and tick beats through the valid/ready input channel with
// random gaps, predicts every output beat with an independent clip and
// Bresenham stepper model, and compares each beat taken from the output
// channel, under random back-pressure, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import pcls_pkg::*;

    localparam int SCR_W        = 640;
    localparam int SCR_H        = 480;
    localparam int RANDOM_BEATS = 1900;
    localparam int MAX_WAIT     = 16;

    // Coordinate ranges for generated endpoints
    typedef enum int {
        SPAN_LOCAL,
        SPAN_EDGE,
        SPAN_FULL,
        SPAN_EXTREME
    } t_span;

    // One predicted output beat
    typedef struct {
        logic [PIXW-1:0] px;
        logic [PIXW-1:0] py;
        logic            plot;
        logic            last;
        logic            rejected;
    } t_pixel;

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_ready;
    logic                   i_command      = CMD_TICK;
    logic signed [IN_W-1:0] i_start_x      = '0;
    logic signed [IN_W-1:0] i_start_y      = '0;
    logic signed [IN_W-1:0] i_end_x        = '0;
    logic signed [IN_W-1:0] i_end_y        = '0;
    logic [PATW-1:0]        i_dash_pattern = '0;
    logic                   o_out_valid;
    logic                   i_out_ready    = 1'b0;
    logic [PIXW-1:0]        o_pixel_x;
    logic [PIXW-1:0]        o_pixel_y;
    logic                   o_plot;
    logic                   o_last;
    logic                   o_rejected;

    // Predicted beats still owed by the block, oldest first
    t_pixel pixel_queue[$];
    int     mismatch_count = 0;
    int     beats_sent     = 0;

    // Idle switches for the two sides; cleared for back-to-back stretches
    bit src_gaps_on   = 1'b1;
    bit snk_stalls_on = 1'b1;

    // Line state mirrored from the block, idle out of reset
    logic [PIXW-1:0]  line_x      = '0;
    logic [PIXW-1:0]  line_y      = '0;
    int               err_acc     = 0;
    logic [PIXW-1:0]  steps_rem   = '0;
    logic             x_dec       = 1'b0;
    logic             y_dec       = 1'b0;
    logic             x_dom       = 1'b0;
    logic [DELW-1:0]  minor2      = '0;
    logic [DELW-1:0]  major2      = '0;
    logic [PATW-1:0]  dash_reg    = '0;
    logic [PIDXW-1:0] dash_idx    = '0;
    logic             line_active = 1'b0;

    patterned_clipped_line_stepper #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_dash_pattern (i_dash_pattern),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_plot         (o_plot),
        .o_last         (o_last),
        .o_rejected     (o_rejected)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int draw_wait(bit on);
        return on ? int'($urandom_range(0, MAX_WAIT)) : 0;
    endfunction

    function automatic logic [3:0] x_outcode(longint x);
        logic [3:0] code;
        code = OC_NONE;
        if (x < 0)      code |= OC_LEFT;
        if (x >= SCR_W) code |= OC_RIGHT;
        return code;
    endfunction

    // Top row counts as outside: rows at or past height-1 are clipped away
    function automatic logic [3:0] outcode(longint x, longint y);
        logic [3:0] code;
        code = x_outcode(x);
        if (y < 0)          code |= OC_BELOW;
        if (y >= SCR_H - 1) code |= OC_ABOVE;
        return code;
    endfunction

    // Truncating division, zero divisor gives zero
    function automatic longint div_trunc(longint num, longint den);
        return (den == 0) ? 64'sd0 : num / den;
    endfunction

    // Clip y first, then x; each endpoint update feeds the next one.
    // Returns 1 when something of the segment survives.
    function automatic bit clip_to_screen(inout longint ax, inout longint ay,
                                          inout longint bx, inout longint by);
        logic [3:0] ca;
        logic [3:0] cb;
        longint     v;
        ca = outcode(ax, ay);
        cb = outcode(bx, by);
        if ((ca & cb) == OC_NONE && (ca | cb) != OC_NONE) begin
            if ((ca & OC_Y_MASK) != OC_NONE) begin
                v  = ((ca & OC_ABOVE) == OC_NONE) ? 0 : SCR_H - 2;
                ax = ax + div_trunc((v - ay) * (bx - ax), by - ay);
                ay = v;
                ca = x_outcode(ax);
            end
            if ((cb & OC_Y_MASK) != OC_NONE) begin
                v  = ((cb & OC_ABOVE) == OC_NONE) ? 0 : SCR_H - 2;
                bx = bx + div_trunc((v - by) * (bx - ax), by - ay);
                by = v;
                cb = x_outcode(bx);
            end
            if ((ca & cb) == OC_NONE && (ca | cb) != OC_NONE) begin
                if (ca != OC_NONE) begin
                    v  = (ca == OC_LEFT) ? 0 : SCR_W - 1;
                    ay = ay + div_trunc((v - ax) * (by - ay), bx - ax);
                    ax = v;
                    ca = OC_NONE;
                end
                if (cb != OC_NONE) begin
                    v  = (cb == OC_LEFT) ? 0 : SCR_W - 1;
                    by = by + div_trunc((v - bx) * (by - ay), bx - ax);
                    bx = v;
                    cb = OC_NONE;
                end
            end
        end
        return (ca | cb) == OC_NONE;
    endfunction

    // Advance the mirrored line by one accepted beat and return its pixel
    function automatic t_pixel predict_beat(logic cmd,
                                            logic signed [IN_W-1:0] sx,
                                            logic signed [IN_W-1:0] sy,
                                            logic signed [IN_W-1:0] ex,
                                            logic signed [IN_W-1:0] ey,
                                            logic [PATW-1:0] pat);
        t_pixel pix;
        longint ax, ay, bx, by, dx, dy, maj, mnr;
        bit     minor_step;
        pix = '{px: '0, py: '0, plot: 1'b0, last: 1'b1, rejected: 1'b0};
        if (cmd == CMD_START) begin
            ax = sx;
            ay = sy;
            bx = ex;
            by = ey;
            dash_reg = pat;
            dash_idx = '0;
            if (!clip_to_screen(ax, ay, bx, by)) begin
                line_active  = 1'b0;
                steps_rem    = '0;
                pix.rejected = 1'b1;
                return pix;
            end
            x_dec = !(ax < bx);
            y_dec = !(ay < by);
            dx    = (ax > bx) ? ax - bx : bx - ax;
            dy    = (ay > by) ? ay - by : by - ay;
            x_dom = dx > dy;
            maj   = x_dom ? dx : dy;
            mnr   = x_dom ? dy : dx;
            major2      = DELW'(2 * maj);
            minor2      = DELW'(2 * mnr);
            err_acc     = int'(2 * mnr - maj);
            steps_rem   = PIXW'(maj);
            line_x      = PIXW'(ax);
            line_y      = PIXW'(ay);
            line_active = steps_rem != 0;
            pix.px   = line_x;
            pix.py   = line_y;
            pix.plot = dash_reg[0];
            pix.last = !line_active;
            return pix;
        end
        // Tick on an idle block answers with an empty last beat
        if (!line_active) return pix;
        minor_step = err_acc >= 0;
        if (minor_step) err_acc += int'(minor2) - int'(major2);
        else            err_acc += int'(minor2);
        if (x_dom) begin
            line_x = x_dec ? line_x - 1'b1 : line_x + 1'b1;
            if (minor_step) line_y = y_dec ? line_y - 1'b1 : line_y + 1'b1;
        end else begin
            line_y = y_dec ? line_y - 1'b1 : line_y + 1'b1;
            if (minor_step) line_x = x_dec ? line_x - 1'b1 : line_x + 1'b1;
        end
        dash_idx    = dash_idx + 1'b1;
        steps_rem   = steps_rem - 1'b1;
        line_active = steps_rem != 0;
        pix.px   = line_x;
        pix.py   = line_y;
        pix.plot = dash_reg[dash_idx];
        pix.last = !line_active;
        return pix;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one beat per call, entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_beat(logic cmd,
                             logic signed [IN_W-1:0] sx, logic signed [IN_W-1:0] sy,
                             logic signed [IN_W-1:0] ex, logic signed [IN_W-1:0] ey,
                             logic [PATW-1:0] pat);
        int gap;
        gap = draw_wait(src_gaps_on);
        // Drop valid only for a real gap, so back-to-back beats keep it high
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_start_x      <= sx;
        i_start_y      <= sy;
        i_end_x        <= ex;
        i_end_y        <= ey;
        i_dash_pattern <= pat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pixel_queue.push_back(predict_beat(cmd, sx, sy, ex, ey, pat));
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Tick with junk in the fields that a tick ignores
    task automatic send_tick();
        send_beat(CMD_TICK, IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
                  IN_W'($urandom), PATW'($urandom));
    endtask

    // Hold the input side until every predicted beat has come out
    task automatic drain_pixels();
        i_in_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, and the check of every beat taken
    // ------------------------------------------------------------------------
    initial begin : sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_wait(snk_stalls_on);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pixel_queue.size() == 0) begin
                $error("output beat with nothing predicted: x=%0d y=%0d",
                       o_pixel_x, o_pixel_y);
                mismatch_count++;
            end else begin
                want = pixel_queue.pop_front();
                if (o_pixel_x !== want.px) begin
                    $error("pixel_x: expected %0d, got %0d", want.px, o_pixel_x);
                    mismatch_count++;
                end
                if (o_pixel_y !== want.py) begin
                    $error("pixel_y: expected %0d, got %0d", want.py, o_pixel_y);
                    mismatch_count++;
                end
                if (o_plot !== want.plot) begin
                    $error("plot: expected %0b, got %0b", want.plot, o_plot);
                    mismatch_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    mismatch_count++;
                end
                if (o_rejected !== want.rejected) begin
                    $error("rejected: expected %0b, got %0b", want.rejected, o_rejected);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Tick right after reset, nothing active
    task automatic test_idle_tick();
        send_tick();
    endtask

    // Start equals end: one pixel, then the block is idle again
    task automatic test_single_pixel();
        send_beat(CMD_START, 16'sd5, 16'sd7, 16'sd5, 16'sd7, 16'h0001);
        send_tick();
    endtask

    // Shallow line forward with an extra idle tick, steep line backward
    task automatic test_short_lines();
        send_beat(CMD_START, 16'sd10, 16'sd10, 16'sd14, 16'sd12, 16'hAAAA);
        repeat (5) send_tick();
        send_beat(CMD_START, 16'sd300, 16'sd200, 16'sd298, 16'sd195, 16'h8001);
        repeat (5) send_tick();
    endtask

    // Fully left; fully past the top row; rejected only after the y clip
    task automatic test_rejected_lines();
        send_beat(CMD_START, -16'sd100, 16'sd5, -16'sd50, 16'sd200, 16'hFFFF);
        send_beat(CMD_START, 16'sd10, 16'sd479, 16'sd600, 16'sd600, 16'hFFFF);
        send_beat(CMD_START, -16'sd300, -16'sd100, 16'sd50, 16'sd700, 16'hFFFF);
    endtask

    // Extreme endpoints clipped in y at both ends; new starts abandon active lines
    task automatic test_clip_extremes();
        send_beat(CMD_START, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
                  16'hFFFF);
        repeat (3) send_tick();
        send_beat(CMD_START, 16'sd639, 16'sd478, 16'sd0, 16'sd0, 16'h0000);
        repeat (2) send_tick();
        send_beat(CMD_START, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
                  16'h5A5A);
        send_tick();
    endtask

    // ------------------------------------------------------------------------
    // Random lines
    // ------------------------------------------------------------------------
    function automatic logic signed [IN_W-1:0] pick_coord(t_span span, int size);
        case (span)
            SPAN_LOCAL: return IN_W'($urandom_range(0, size - 1));
            SPAN_EDGE:  return IN_W'(int'($urandom_range(0, size + 119)) - 60);
            SPAN_FULL:  return IN_W'($urandom);
            default: begin
                case ($urandom_range(0, 6))
                    0:       return -16'sd32768;
                    1:       return 16'sd32767;
                    2:       return -16'sd1;
                    3:       return 16'sd0;
                    4:       return IN_W'(size - 1);
                    5:       return IN_W'(size - 2);
                    default: return IN_W'(size);
                endcase
            end
        endcase
    endfunction

    // Endpoint a short random offset away, so most lines stay short
    function automatic logic signed [IN_W-1:0] near_coord(logic signed [IN_W-1:0] c,
                                                          int reach);
        int off;
        off = $urandom_range(0, 2 * reach);
        return IN_W'(int'(c) + off - reach);
    endfunction

    task automatic test_random_lines();
        int                     first_beat;
        int                     budget;
        int                     cap;
        int                     roll;
        bit                     run_out;
        t_span                  span;
        logic signed [IN_W-1:0] sx, sy, ex, ey;
        first_beat = beats_sent;
        while (beats_sent - first_beat < RANDOM_BEATS) begin
            // Switch idling on and off now and then for burst stretches
            if ($urandom_range(0, 15) == 0) begin
                src_gaps_on   = $urandom_range(0, 2) != 0;
                snk_stalls_on = $urandom_range(0, 2) != 0;
            end
            if ($urandom_range(0, 299) == 0) drain_pixels();
            // Stray ticks, mostly hitting an idle block
            if ($urandom_range(0, 99) < 6) begin
                send_tick();
                continue;
            end
            roll = $urandom_range(0, 99);
            span = (roll < 60) ? SPAN_LOCAL : (roll < 85) ? SPAN_EDGE :
                   (roll < 93) ? SPAN_FULL : SPAN_EXTREME;
            sx = pick_coord(span, SCR_W);
            sy = pick_coord(span, SCR_H);
            if (span == SPAN_LOCAL) begin
                ex = near_coord(sx, 24);
                ey = near_coord(sy, 24);
            end else if (span == SPAN_EDGE) begin
                ex = near_coord(sx, 90);
                ey = near_coord(sy, 90);
            end else begin
                ex = pick_coord(span, SCR_W);
                ey = pick_coord(span, SCR_H);
            end
            send_beat(CMD_START, sx, sy, ex, ey, PATW'($urandom));
            // Mostly finish the line; sometimes cut it short with a new start
            run_out = (span == SPAN_LOCAL || span == SPAN_EDGE) ?
                      ($urandom_range(0, 6) != 0) : ($urandom_range(0, 3) == 0);
            if (!line_active) begin
                budget = $urandom_range(0, 1);
            end else if (run_out) begin
                budget = int'(steps_rem) + int'($urandom_range(0, 1));
            end else begin
                cap    = (steps_rem < 30) ? int'(steps_rem) : 30;
                budget = $urandom_range(0, cap);
            end
            repeat (budget) send_tick();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_tick();
        test_single_pixel();
        test_short_lines();
        test_rejected_lines();
        test_clip_extremes();
        // Hold the sender until the directed beats are all back
        drain_pixels();
        test_random_lines();

        drain_pixels();
        // Leave room for any stray beat after the last expected one
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/pcls_pkg.sv
rtl/core/pcls_muldiv.sv
rtl/core/patterned_clipped_line_stepper.sv
tb/tb_top.sv
